// ===== src/flood_and_ban_rate_limiter_core_macros.svh =====
// Assertion macros used by the rate limiter core.
`ifndef FLOOD_AND_BAN_RATE_LIMITER_CORE_MACROS_SVH
`define FLOOD_AND_BAN_RATE_LIMITER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FBRL_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rate limiter check failed");
`define FBRL_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rate limiter check failed");
`else
`define FBRL_ASSERT(lbl, cond)
`define FBRL_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== src/fbrl_pkg.sv =====
// Types and constants of the flood and ban rate limiter.
package fbrl_pkg;
	localparam int WINDOW_DEPTH_DEF = 64;
	localparam int TIME_BITS_DEF = 48;
	localparam int THR_BITS = 27;
	localparam logic [THR_BITS-1:0] MS_PER_MIN = 27'd60000;

	localparam logic [9:0] FLOOD_MIN_RST = 10'd5;
	localparam logic [9:0] BAN_MIN_RST = 10'd60;
	localparam logic [5:0] MAX_LOGINS_RST = 6'd4;
	localparam logic [5:0] MAX_BIG_RST = 6'd4;
	localparam logic [5:0] MAX_MSGS_RST = 6'd50;
	localparam logic [31:0] MAX_SIZE_RST = 32'd536870912;

	localparam logic [2:0] REG_FLOOD_MIN = 3'd0;
	localparam logic [2:0] REG_BAN_MIN = 3'd1;
	localparam logic [2:0] REG_MAX_LOGINS = 3'd2;
	localparam logic [2:0] REG_MAX_BIG = 3'd3;
	localparam logic [2:0] REG_MAX_MSGS = 3'd4;
	localparam logic [2:0] REG_MAX_SIZE = 3'd5;

	localparam logic [1:0] KIND_PLAIN = 2'd0;
	localparam logic [1:0] KIND_LOGIN = 2'd1;
	localparam logic [1:0] KIND_BIG = 2'd2;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_FLOOD = 2'd1;
	localparam logic [1:0] MODE_BAN = 2'd2;

	localparam logic [2:0] V_PASS = 3'd0;
	localparam logic [2:0] V_BLK_FLOOD = 3'd1;
	localparam logic [2:0] V_BLK_BAN = 3'd2;
	localparam logic [2:0] V_RELEASED = 3'd3;
	localparam logic [2:0] V_LOGIN_BAN = 3'd4;
	localparam logic [2:0] V_BIG_BAN = 3'd5;
	localparam logic [2:0] V_FLOOD_START = 3'd6;

	typedef struct packed {
		logic [9:0] flood_minutes;
		logic [9:0] ban_minutes;
		logic [5:0] max_logins;
		logic [5:0] max_oversized;
		logic [5:0] max_messages;
		logic [31:0] max_size;
	} cfg_t;
endpackage

// ===== src/flood_and_ban_rate_limiter_core.sv =====
// Top level of the flood and ban rate limiter for one client stream.
// Each request (a message time in ms, a size and a login flag) yields one
// result: a verdict and an oversized flag. The window of message records
// (kind and time) lives in one RAM of WINDOW_DEPTH entries, registered read.
// In normal mode the block streams the stored records through that RAM, one
// entry per cycle, drops stale ones and compacts the survivors in place while
// counting logins, oversized records and the total. In flood or ban mode
// only the mode timer is checked and the record window is not read.
// A finished result sits in an output register, so the next request is taken
// while the last result still waits. No clearing pass after reset: only
// entries below the record count are ever read. Configuration writes are
// taken in every cycle and are meant for idle periods.
module flood_and_ban_rate_limiter_core #(
	parameter int WINDOW_DEPTH = fbrl_pkg::WINDOW_DEPTH_DEF,
	parameter int TIME_BITS = fbrl_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_BITS-1:0] now_ms,
	input  logic [31:0]          msg_size,
	input  logic                 is_login,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           verdict,
	output logic                 oversized,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	`include "flood_and_ban_rate_limiter_core_macros.svh"

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int RW = 2 + TIME_BITS;
	localparam int CMPW = (CW > 6) ? CW : 6;
	localparam int TB = fbrl_pkg::THR_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	fbrl_pkg::cfg_t cfg;

	logic [1:0]           state_q;
	logic [1:0]           mode_q;
	logic [TIME_BITS-1:0] mode_start_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rd_idx_q;
	logic [CW-1:0]        kept_q;
	logic [CW-1:0]        nlog_q;
	logic [CW-1:0]        nbig_q;
	logic                 vld_s1;
	logic [TIME_BITS-1:0] now_q;
	logic [1:0]           kind_q;
	logic                 big_q;
	logic [TB-1:0]        flood_ms_q;
	logic [TB-1:0]        ban_ms_q;
	logic                 out_valid_q;
	logic [2:0]           verdict_q;
	logic                 oversized_q;

	logic                 accept;
	logic                 rd_go;
	logic [RW-1:0]        rdata;
	logic [1:0]           rec_kind;
	logic [TIME_BITS-1:0] rec_time;
	logic [TB-1:0]        rec_lim;
	logic [TIME_BITS-1:0] rec_diff;
	logic                 stale;
	logic                 keep;
	logic                 fin_fire;
	logic                 blocked;
	logic [TB-1:0]        mode_lim;
	logic [TIME_BITS-1:0] mode_diff;
	logic                 ban_login;
	logic                 ban_big;
	logic                 flood_go;
	logic                 push;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [RW-1:0]        ram_wdata;
	logic                 msg_big;

	fbrl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign msg_big = msg_size > cfg.max_size;

	// Record stream: read one entry per cycle, judge it when it returns.
	assign rd_go = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign rec_kind = rdata[RW-1 -: 2];
	assign rec_time = rdata[TIME_BITS-1:0];
	assign rec_lim = (rec_kind == fbrl_pkg::KIND_LOGIN || rec_kind == fbrl_pkg::KIND_BIG) ?
		ban_ms_q : flood_ms_q;
	assign rec_diff = now_q - rec_time;
	// Whole minutes exceed the limit once the gap reaches (limit + 1) minutes.
	assign stale = (now_q >= rec_time) &&
		(rec_diff >= TIME_BITS'(rec_lim) + TIME_BITS'(fbrl_pkg::MS_PER_MIN));
	assign keep = vld_s1 && !stale;

	// Mode timer and final decision.
	assign mode_lim = (mode_q == fbrl_pkg::MODE_BAN) ? ban_ms_q : flood_ms_q;
	assign mode_diff = now_q - mode_start_q;
	assign blocked = (now_q < mode_start_q) ? (mode_lim != '0) :
		(mode_diff < TIME_BITS'(mode_lim));
	assign ban_login = CMPW'(nlog_q) > CMPW'(cfg.max_logins);
	assign ban_big = CMPW'(nbig_q) > CMPW'(cfg.max_oversized);
	assign flood_go = CMPW'(kept_q) > CMPW'(cfg.max_messages);
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		push = 1'b0;
		if (mode_q != fbrl_pkg::MODE_NORMAL) begin
			push = !blocked;
		end else if (!ban_login && !ban_big && !flood_go) begin
			push = kept_q < CW'(WINDOW_DEPTH);
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = kept_q[AW-1:0];
		ram_wdata = rdata;
		if (state_q == ST_SCAN) begin
			ram_we = keep;
		end else if (fin_fire && push) begin
			ram_we = 1'b1;
			ram_wdata = {kind_q, now_q};
			if (mode_q != fbrl_pkg::MODE_NORMAL) begin
				ram_waddr = '0;
			end
		end
	end

	fbrl_ram #(
		.WIDTH(RW),
		.DEPTH(WINDOW_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_go),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// Item payload and thresholds in ms; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= now_ms;
			big_q <= msg_big;
			kind_q <= msg_big ? fbrl_pkg::KIND_BIG :
				(is_login ? fbrl_pkg::KIND_LOGIN : fbrl_pkg::KIND_PLAIN);
			flood_ms_q <= TB'(cfg.flood_minutes) * fbrl_pkg::MS_PER_MIN;
			ban_ms_q <= TB'(cfg.ban_minutes) * fbrl_pkg::MS_PER_MIN;
		end
		if (fin_fire) begin
			oversized_q <= big_q;
			if (mode_q != fbrl_pkg::MODE_NORMAL) begin
				verdict_q <= !blocked ? fbrl_pkg::V_RELEASED :
					((mode_q == fbrl_pkg::MODE_BAN) ? fbrl_pkg::V_BLK_BAN :
						fbrl_pkg::V_BLK_FLOOD);
			end else if (ban_login) begin
				verdict_q <= fbrl_pkg::V_LOGIN_BAN;
			end else if (ban_big) begin
				verdict_q <= fbrl_pkg::V_BIG_BAN;
			end else if (flood_go) begin
				verdict_q <= fbrl_pkg::V_FLOOD_START;
			end else begin
				verdict_q <= fbrl_pkg::V_PASS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= fbrl_pkg::MODE_NORMAL;
			mode_start_q <= '0;
			count_q <= '0;
			rd_idx_q <= '0;
			kept_q <= '0;
			nlog_q <= '0;
			nbig_q <= '0;
			vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						kept_q <= '0;
						nlog_q <= '0;
						nbig_q <= '0;
						vld_s1 <= 1'b0;
						state_q <= (mode_q == fbrl_pkg::MODE_NORMAL) ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= rd_go;
					if (rd_go) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (keep) begin
						kept_q <= kept_q + 1'b1;
						if (rec_kind == fbrl_pkg::KIND_LOGIN) begin
							nlog_q <= nlog_q + 1'b1;
						end else if (rec_kind == fbrl_pkg::KIND_BIG) begin
							nbig_q <= nbig_q + 1'b1;
						end
					end
					if (!rd_go && !vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
						if (mode_q != fbrl_pkg::MODE_NORMAL) begin
							if (!blocked) begin
								mode_q <= fbrl_pkg::MODE_NORMAL;
								count_q <= CW'(1);
							end
						end else if (ban_login || ban_big) begin
							mode_q <= fbrl_pkg::MODE_BAN;
							mode_start_q <= now_q;
							count_q <= '0;
						end else if (flood_go) begin
							mode_q <= fbrl_pkg::MODE_FLOOD;
							mode_start_q <= now_q;
							count_q <= kept_q;
						end else begin
							count_q <= push ? kept_q + 1'b1 : kept_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;
	assign oversized = oversized_q;

	// Window never holds more records than the RAM has entries.
	`FBRL_ASSERT(a_count_bound, count_q <= CW'(WINDOW_DEPTH))
	// Compaction writes always land behind the read pointer.
	`FBRL_ASSERT(a_compact_order, !(state_q == ST_SCAN && keep) || (kept_q < rd_idx_q))
	// An accepted request always leaves the idle state.
	`FBRL_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE)
	// Mode only ever holds normal, flood or ban; flood and ban only come from the normal mode decision.
	`FBRL_ASSERT(a_mode_legal, mode_q == fbrl_pkg::MODE_NORMAL || mode_q == fbrl_pkg::MODE_FLOOD || mode_q == fbrl_pkg::MODE_BAN)
endmodule

// ===== src/fbrl_ram.sv =====
// Generic single write, single read RAM with registered read data.
module fbrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== src/fbrl_cfg.sv =====
// Configuration register file of the rate limiter.
module fbrl_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output fbrl_pkg::cfg_t      cfg
);
	fbrl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flood_minutes <= fbrl_pkg::FLOOD_MIN_RST;
			cfg_q.ban_minutes <= fbrl_pkg::BAN_MIN_RST;
			cfg_q.max_logins <= fbrl_pkg::MAX_LOGINS_RST;
			cfg_q.max_oversized <= fbrl_pkg::MAX_BIG_RST;
			cfg_q.max_messages <= fbrl_pkg::MAX_MSGS_RST;
			cfg_q.max_size <= fbrl_pkg::MAX_SIZE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				fbrl_pkg::REG_FLOOD_MIN: cfg_q.flood_minutes <= cfg_data[9:0];
				fbrl_pkg::REG_BAN_MIN: cfg_q.ban_minutes <= cfg_data[9:0];
				fbrl_pkg::REG_MAX_LOGINS: cfg_q.max_logins <= cfg_data[5:0];
				fbrl_pkg::REG_MAX_BIG: cfg_q.max_oversized <= cfg_data[5:0];
				fbrl_pkg::REG_MAX_MSGS: cfg_q.max_messages <= cfg_data[5:0];
				fbrl_pkg::REG_MAX_SIZE: cfg_q.max_size <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== tb/flood_and_ban_rate_limiter_core_tb.sv =====
// Self-checking testbench for the flood and ban rate limiter core.
`timescale 1ns / 1ps

module flood_and_ban_rate_limiter_core_tb;
	import fbrl_pkg::*;

	localparam int DEPTH = WINDOW_DEPTH_DEF;
	localparam int TB = TIME_BITS_DEF;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [TB-1:0] TIME_MAX = {TB{1'b1}};

	typedef struct packed {
		logic [2:0] verdict;
		logic       oversized;
	} verdict_t;

	typedef struct {
		logic [TB-1:0] now;
		logic [31:0]   size;
		logic          login;
		bit            typed;
		logic [2:0]    verdict;
		logic          oversized;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TB-1:0] now_ms = '0;
	logic [31:0] msg_size = '0;
	logic is_login = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] verdict;
	logic oversized;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	flood_and_ban_rate_limiter_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.now_ms(now_ms), .msg_size(msg_size), .is_login(is_login),
		.out_valid(out_valid), .out_ready(out_ready),
		.verdict(verdict), .oversized(oversized),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Limiter shadow: configuration, mode and record window
	cfg_t          lim_cfg;
	logic [1:0]    lim_mode;
	logic [TB-1:0] lim_mode_start;
	logic [1:0]    win_kind [DEPTH];
	logic [TB-1:0] win_time [DEPTH];
	int            win_count;

	verdict_t verdict_q [$];
	verdict_t got_exp;
	int err_count = 0;
	int item_count = 0;
	int cfg_count = 0;
	int result_count = 0;
	int cycle_count = 0;
	int bans_seen = 0;
	int floods_seen = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	logic [TB-1:0] t_cur;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, result_count);
		err_count++;
	endtask

	function automatic logic [63:0] mins_between(input logic [TB-1:0] now, input logic [TB-1:0] then);
		if (now < then)
			return 64'd0;
		return (64'(now) - 64'(then)) / 64'd60000;
	endfunction

	// Works out one message's verdict and updates the shadow state
	function automatic verdict_t police_msg(input logic [TB-1:0] now, input logic [31:0] size,
			input logic login);
		verdict_t r;
		logic [1:0] kind;
		logic [63:0] lim;
		int kept, n_login, n_big;
		r.oversized = size > lim_cfg.max_size;
		kind = r.oversized ? KIND_BIG : (login ? KIND_LOGIN : KIND_PLAIN);
		kept = 0;
		n_login = 0;
		n_big = 0;
		if (lim_mode != MODE_NORMAL) begin
			lim = (lim_mode == MODE_BAN) ? 64'(lim_cfg.ban_minutes) : 64'(lim_cfg.flood_minutes);
			if (mins_between(now, lim_mode_start) < lim) begin
				r.verdict = (lim_mode == MODE_BAN) ? V_BLK_BAN : V_BLK_FLOOD;
			end else begin
				lim_mode = MODE_NORMAL;
				win_kind[0] = kind;
				win_time[0] = now;
				win_count = 1;
				r.verdict = V_RELEASED;
			end
			return r;
		end
		for (int i = 0; i < win_count; i++) begin
			lim = (win_kind[i] == KIND_PLAIN) ? 64'(lim_cfg.flood_minutes) :
				64'(lim_cfg.ban_minutes);
			if (mins_between(now, win_time[i]) <= lim) begin
				win_kind[kept] = win_kind[i];
				win_time[kept] = win_time[i];
				kept++;
				if (win_kind[i] == KIND_LOGIN)
					n_login++;
				else if (win_kind[i] == KIND_BIG)
					n_big++;
			end
		end
		win_count = kept;
		if (n_login > lim_cfg.max_logins) begin
			win_count = 0;
			lim_mode = MODE_BAN;
			lim_mode_start = now;
			r.verdict = V_LOGIN_BAN;
		end else if (n_big > lim_cfg.max_oversized) begin
			win_count = 0;
			lim_mode = MODE_BAN;
			lim_mode_start = now;
			r.verdict = V_BIG_BAN;
		end else if (win_count > lim_cfg.max_messages) begin
			lim_mode = MODE_FLOOD;
			lim_mode_start = now;
			r.verdict = V_FLOOD_START;
		end else begin
			if (win_count < DEPTH) begin
				win_kind[win_count] = kind;
				win_time[win_count] = now;
				win_count++;
			end
			r.verdict = V_PASS;
		end
		return r;
	endfunction

	// Offer one request; returns at the edge where it is taken, valid still high
	task automatic offer(input logic [TB-1:0] t, input logic [31:0] s, input logic l,
			input bit typed, input verdict_t typed_exp);
		verdict_t p;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		msg_size <= s;
		is_login <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p = police_msg(t, s, l);
		if (p.verdict inside {V_LOGIN_BAN, V_BIG_BAN})
			bans_seen++;
		if (p.verdict == V_FLOOD_START)
			floods_seen++;
		verdict_q.push_back(typed ? typed_exp : p);
		item_count++;
	endtask

	// Drop valid, let every result come back, then cover a full window scan
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FLOOD_MIN:  lim_cfg.flood_minutes = data[9:0];
			REG_BAN_MIN:    lim_cfg.ban_minutes = data[9:0];
			REG_MAX_LOGINS: lim_cfg.max_logins = data[5:0];
			REG_MAX_BIG:    lim_cfg.max_oversized = data[5:0];
			REG_MAX_MSGS:   lim_cfg.max_messages = data[5:0];
			REG_MAX_SIZE:   lim_cfg.max_size = data;
			default: ;
		endcase
		cfg_count++;
		@(posedge clk);
	endtask

	task automatic load_cfg(input cfg_t c);
		write_reg(REG_FLOOD_MIN, 32'(c.flood_minutes));
		write_reg(REG_BAN_MIN, 32'(c.ban_minutes));
		write_reg(REG_MAX_LOGINS, 32'(c.max_logins));
		write_reg(REG_MAX_BIG, 32'(c.max_oversized));
		write_reg(REG_MAX_MSGS, 32'(c.max_messages));
		write_reg(REG_MAX_SIZE, c.max_size);
	endtask

	// Mostly sub-second steps so windows fill; rare long jumps age them out
	task automatic random_msgs(input int n);
		logic [63:0] step;
		logic [63:0] nxt;
		logic [31:0] s;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 999);
			if (r < 880)
				step = 64'($urandom_range(0, 400));
			else if (r < 985)
				step = 64'($urandom_range(0, 10000));
			else if (r < 995)
				step = 64'($urandom_range(60000, 600000));
			else
				step = 64'($urandom_range(0, 72000000));
			nxt = 64'(t_cur) + step;
			t_cur = (nxt > 64'(TIME_MAX)) ? TIME_MAX : nxt[TB-1:0];
			r = $urandom_range(0, 99);
			if (r < 40)
				s = $urandom_range(0, 1000);
			else if (r < 70)
				s = lim_cfg.max_size + 32'($urandom_range(0, 2)) - 32'd1;
			else
				s = $urandom;
			if (i == n / 3 && idle_on)
				hold_req = 1'b1;
			offer(t_cur, s, $urandom_range(0, 2) == 0, 1'b0, '0);
		end
	endtask

	row_t dir_rows [18];
	cfg_t sweep [4];

	initial begin
		// After reset: plain pass, size boundary, five logins pass, sixth bans
		dir_rows[0] = '{48'd0, 32'd0, 1'b0, 1'b1, V_PASS, 1'b0};
		dir_rows[1] = '{48'd0, 32'd536870912, 1'b0, 1'b1, V_PASS, 1'b0};
		dir_rows[2] = '{48'd0, 32'd536870913, 1'b0, 1'b1, V_PASS, 1'b1};
		for (int i = 3; i < 8; i++)
			dir_rows[i] = '{48'd0, 32'd7, 1'b1, 1'b1, V_PASS, 1'b0};
		dir_rows[8] = '{48'd0, 32'd7, 1'b1, 1'b1, V_LOGIN_BAN, 1'b0};
		dir_rows[9] = '{48'd1000, 32'd0, 1'b0, 1'b1, V_BLK_BAN, 1'b0};
		// Exactly the ban time elapsed: released, window holds only this record
		dir_rows[10] = '{48'd3600000, 32'd0, 1'b0, 1'b1, V_RELEASED, 1'b0};
		// Oversized login counts as oversized; sixth one bans
		for (int i = 11; i < 16; i++)
			dir_rows[i] = '{48'd3600000, 32'hFFFF_FFFF, 1'b1, 1'b1, V_PASS, 1'b1};
		dir_rows[16] = '{48'd3600000, 32'hFFFF_FFFF, 1'b1, 1'b1, V_BIG_BAN, 1'b1};
		dir_rows[17] = '{48'd3600001, 32'd1, 1'b0, 1'b0, V_PASS, 1'b0};

		sweep[0] = '{10'd0, 10'd0, 6'd0, 6'd0, 6'd0, 32'd0};
		sweep[1] = '{10'd1023, 10'd1023, 6'd62, 6'd62, 6'd62, 32'hFFFF_FFFF};
		sweep[2] = '{10'd1, 10'd3, 6'd2, 6'd3, 6'd10, 32'd5000};
		sweep[3] = '{FLOOD_MIN_RST, BAN_MIN_RST, MAX_LOGINS_RST, MAX_BIG_RST,
			MAX_MSGS_RST, MAX_SIZE_RST};

		lim_cfg = '{FLOOD_MIN_RST, BAN_MIN_RST, MAX_LOGINS_RST, MAX_BIG_RST,
			MAX_MSGS_RST, MAX_SIZE_RST};
		lim_mode = MODE_NORMAL;
		lim_mode_start = '0;
		win_count = 0;
		t_cur = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].now, dir_rows[i].size, dir_rows[i].login, dir_rows[i].typed,
				'{dir_rows[i].verdict, dir_rows[i].oversized});
		t_cur = dir_rows[17].now;

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			// Last setting: no idling, and time jumps high to exercise the upper bits
			if (ph == 3) begin
				idle_on = 1'b0;
				t_cur = TIME_MAX - 48'd500000000;
			end
			load_cfg(sweep[ph]);
			random_msgs(90);
			// Sender pause: wait for every outstanding verdict mid-setting
			drain();
			random_msgs(90);
		end
		drain();

		if (verdict_q.size() != 0)
			report("leftover expectations", 32'(verdict_q.size()), 32'd0);
		$display("Covered %0d requests, %0d results, %0d register writes over 4 settings",
			item_count, result_count, cfg_count);
		$display("Saw %0d ban entries and %0d flood entries", bans_seen, floods_seen);
		if (err_count == 0)
			$display("flood_and_ban_rate_limiter_core_tb: clean");
		else
			$display("flood_and_ban_rate_limiter_core_tb: errors");
		$finish;
	end

	// Receiver: random stall bursts, plus long holds that back up the block
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Result checker: compare each taken result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (verdict_q.size() == 0) begin
				report("result with nothing expected", 32'(verdict), 32'd0);
			end else begin
				got_exp = verdict_q.pop_front();
				if (verdict !== got_exp.verdict)
					report("verdict", 32'(verdict), 32'(got_exp.verdict));
				if (oversized !== got_exp.oversized)
					report("oversized", 32'(oversized), 32'(got_exp.oversized));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("flood_and_ban_rate_limiter_core_tb: errors");
			$finish;
		end
	end

endmodule
